>>> src/spfc_pkg.sv
`default_nettype none

package spfc_pkg;

   // Body and payload geometry
   localparam int BODY_BYTES    = 64;
   localparam int PAYLOAD_BYTES = 60;
   localparam int BODY_AW       = $clog2(BODY_BYTES);
   localparam int PAY_W         = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

   // Request message limits
   localparam int REQ_MAX_BYTES = 8;

   // Configuration port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_RELOAD = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_REQUEST_BYTES  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_REQUEST_LENGTH = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_PAYLOAD_OFFSET = CSR_IDX_W'(3);

   // Event kinds
   localparam logic [1:0] FUNC_RX      = 2'd0;
   localparam logic [1:0] FUNC_TICK    = 2'd1;
   localparam logic [1:0] FUNC_TX_DONE = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_TX      = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_FAIL    = 2'd2;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] rx_data;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [5:0] position;
      logic       last;
   } rsp_type;

endpackage

`default_nettype wire

>>> src/serial_poll_frame_checksum_unit.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// req_      in         req_valid/req_ready    req_data (func, rx_data)
// rsp_      out        rsp_valid/rsp_ready    rsp_data (kind, data, position, last)
// csr_      in         csr_we                 csr_index, csr_wdata
//
// One request at a time. A request that does not poll passes from decide to the
// transmit state and back to idle, emitting a transmit byte when one is pending. A
// polling request adds one sweep over the body memory's read port, then a read and
// an emit per payload byte, or a single failure result on a checksum failure.
// Synchronous active-high reset clears control state and the per-entry valid
// bits, so the body reads as zero without a clearing pass.
// Results are held in an output register; a stall on rsp_ready holds the
// sequencer, and a waiting result never blocks acceptance of the next request.
module serial_poll_frame_checksum_unit (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_ready,
   input  spfc_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output spfc_pkg::rsp_type               rsp_data,
   input  wire                             csr_we,
   input  wire  [spfc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire  [spfc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import spfc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SUM,
      ST_CHECK,
      ST_TX,
      ST_FAIL,
      ST_PRD,
      ST_PEMIT
   } state_type;

   // Configuration registers
   logic [7:0]  timeout_reload_ff;
   logic [63:0] request_bytes_ff;
   logic [3:0]  request_length_ff;
   logic [5:0]  payload_offset_ff;

   // Control state
   state_type          state_ff;
   logic [BODY_AW-1:0] rcv_idx_ff;
   logic               complete_ff;
   logic               rx_on_ff;
   logic               sending_ff;
   logic [3:0]         send_idx_ff;
   logic [7:0]         timeout_ff;
   logic               poll_ff;
   logic               ok_ff;
   logic [BODY_AW-1:0] sum_cnt_ff;
   logic [7:0]         sum_ff;
   logic [PAY_W-1:0]   pay_idx_ff;

   // Pending transmit byte
   logic               tx_pend_ff;
   logic [7:0]         tx_data_ff;
   logic [3:0]         tx_pos_ff;

   // Output register
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   // Body memory, with per-entry valid bits standing in for the zero reset
   logic [7:0]            body_mem [BODY_BYTES];
   logic [BODY_BYTES-1:0] body_vld_ff;
   logic [7:0]            rd_data_ff;
   logic                  rd_vld_ff;

   logic                  accept;
   logic                  out_free;
   logic                  emit_now;
   logic                  mem_we;
   logic [BODY_AW-1:0]    raddr;
   logic [6:0]            pay_sum;
   logic [7:0]            rd_byte;
   logic [3:0]            len_sat;
   logic                  step_emit;
   logic [7:0]            step_byte;
   logic                  poll_now;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Load the output register this cycle
   assign emit_now  = out_free && (((state_ff == ST_TX) && tx_pend_ff) ||
                                   (state_ff == ST_FAIL) || (state_ff == ST_PEMIT));

   assign mem_we  = accept && (req_data.func == FUNC_RX) && rx_on_ff;
   assign rd_byte = rd_vld_ff ? rd_data_ff : 8'h00;

   // Payload read index clamps to the last body byte
   assign pay_sum = 7'(pay_idx_ff) + 7'(payload_offset_ff);

   always_comb begin
      if (state_ff == ST_SUM) begin
         raddr = sum_cnt_ff;
      end else if (pay_sum > 7'(BODY_BYTES - 1)) begin
         raddr = BODY_AW'(BODY_BYTES - 1);
      end else begin
         raddr = BODY_AW'(pay_sum);
      end
   end

   // One send step: emit the next request byte, or end the send
   assign len_sat   = (request_length_ff > 4'(REQ_MAX_BYTES)) ? 4'(REQ_MAX_BYTES)
                                                               : request_length_ff;
   assign step_emit = (send_idx_ff < len_sat);
   assign step_byte = request_bytes_ff[{send_idx_ff[2:0], 3'b000} +: 8];

   assign poll_now  = complete_ff || (timeout_ff == 8'h00);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_reload_ff <= 8'h00;
         request_bytes_ff  <= 64'h0;
         request_length_ff <= 4'd1;
         payload_offset_ff <= 6'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TIMEOUT_RELOAD: timeout_reload_ff <= csr_wdata[7:0];
            CSR_REQUEST_BYTES:  request_bytes_ff  <= csr_wdata[63:0];
            CSR_REQUEST_LENGTH: request_length_ff <= csr_wdata[3:0];
            CSR_PAYLOAD_OFFSET: payload_offset_ff <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   // Body memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         body_mem[rcv_idx_ff] <= req_data.rx_data;
      end
      rd_data_ff <= body_mem[raddr];
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rcv_idx_ff   <= '0;
         complete_ff  <= 1'b1;
         rx_on_ff     <= 1'b1;
         sending_ff   <= 1'b0;
         send_idx_ff  <= 4'd0;
         timeout_ff   <= 8'h00;
         poll_ff      <= 1'b0;
         ok_ff        <= 1'b0;
         tx_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         body_vld_ff  <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         rd_vld_ff <= body_vld_ff[raddr];
         if (emit_now) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_DECIDE;
                  unique case (req_data.func)
                     FUNC_RX: begin
                        if (rx_on_ff) begin
                           body_vld_ff[rcv_idx_ff] <= 1'b1;
                           if (rcv_idx_ff == BODY_AW'(BODY_BYTES - 1)) begin
                              rcv_idx_ff  <= '0;
                              complete_ff <= 1'b1;
                           end else begin
                              rcv_idx_ff <= rcv_idx_ff + 1'b1;
                           end
                        end
                     end
                     FUNC_TICK: begin
                        if (timeout_ff != 8'h00) begin
                           timeout_ff <= timeout_ff - 8'h01;
                        end
                     end
                     FUNC_TX_DONE: begin
                        if (step_emit) begin
                           tx_pend_ff  <= 1'b1;
                           tx_data_ff  <= step_byte;
                           tx_pos_ff   <= send_idx_ff;
                           sending_ff  <= 1'b1;
                           send_idx_ff <= send_idx_ff + 4'd1;
                        end else begin
                           rx_on_ff    <= 1'b1;
                           sending_ff  <= 1'b0;
                           send_idx_ff <= 4'd0;
                        end
                     end
                     default: ;
                  endcase
               end
            end

            ST_DECIDE: begin
               poll_ff <= poll_now;
               if (poll_now) begin
                  // Start a send unless one is under way
                  if (!sending_ff) begin
                     if (step_emit) begin
                        rx_on_ff    <= 1'b0;
                        tx_pend_ff  <= 1'b1;
                        tx_data_ff  <= step_byte;
                        tx_pos_ff   <= send_idx_ff;
                        sending_ff  <= 1'b1;
                        send_idx_ff <= send_idx_ff + 4'd1;
                     end else begin
                        rx_on_ff    <= 1'b1;
                        sending_ff  <= 1'b0;
                        send_idx_ff <= 4'd0;
                     end
                  end
                  complete_ff <= 1'b0;
                  timeout_ff  <= timeout_reload_ff;
                  sum_cnt_ff  <= '0;
                  sum_ff      <= 8'h00;
                  state_ff    <= ST_SUM;
               end else begin
                  state_ff <= ST_TX;
               end
            end

            ST_SUM: begin
               // Read data arrives in the cycle after its address
               if (sum_cnt_ff != '0) begin
                  sum_ff <= sum_ff + rd_byte;
               end
               if (sum_cnt_ff == BODY_AW'(BODY_BYTES - 1)) begin
                  state_ff <= ST_CHECK;
               end else begin
                  sum_cnt_ff <= sum_cnt_ff + 1'b1;
               end
            end

            ST_CHECK: begin
               ok_ff      <= ((8'h00 - sum_ff) == rd_byte);
               pay_idx_ff <= '0;
               state_ff   <= ST_TX;
            end

            ST_TX: begin
               if (!tx_pend_ff) begin
                  state_ff <= !poll_ff ? ST_IDLE : (ok_ff ? ST_PRD : ST_FAIL);
               end else if (out_free) begin
                  rsp_ff.kind      <= KIND_TX;
                  rsp_ff.data      <= tx_data_ff;
                  rsp_ff.position  <= 6'(tx_pos_ff);
                  rsp_ff.last      <= !poll_ff;
                  tx_pend_ff       <= 1'b0;
               end
            end

            ST_FAIL: begin
               if (out_free) begin
                  rsp_ff.kind     <= KIND_FAIL;
                  rsp_ff.data     <= 8'h00;
                  rsp_ff.position <= 6'd0;
                  rsp_ff.last     <= 1'b1;
                  state_ff        <= ST_IDLE;
               end
            end

            ST_PRD: begin
               state_ff <= ST_PEMIT;
            end

            ST_PEMIT: begin
               if (out_free) begin
                  rsp_ff.kind     <= KIND_PAYLOAD;
                  rsp_ff.data     <= rd_byte;
                  rsp_ff.position <= 6'(pay_idx_ff);
                  rsp_ff.last     <= (pay_idx_ff == PAY_W'(PAYLOAD_BYTES - 1));
                  if (pay_idx_ff == PAY_W'(PAYLOAD_BYTES - 1)) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     pay_idx_ff <= pay_idx_ff + 1'b1;
                     state_ff   <= ST_PRD;
                  end
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // A request is worked on alone
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in flight");

   // A send under way has always emitted at least its first byte
   a_send_index_moves: assert property (@(posedge clock) disable iff (reset)
      sending_ff |-> (send_idx_ff != 4'd0))
      else $error("send under way with send index at zero");

   // A checksum failure always closes the results of its request
   a_fail_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.kind == KIND_FAIL)) |-> rsp_data.last)
      else $error("checksum failure not marked last");

   // Payload is only emitted after a passing checksum of a polling request
   a_payload_after_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PEMIT) |-> (ok_ff && poll_ff && !tx_pend_ff))
      else $error("payload emitted without a passing poll");

endmodule

`default_nettype wire

>>> tb/serial_poll_frame_checker.sv
module serial_poll_frame_checker (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   input  wire                                req_ready,
   input  spfc_pkg::req_type                  req_data,
   input  wire                                rsp_valid,
   input  wire                                rsp_ready,
   input  spfc_pkg::rsp_type                  rsp_data,
   input  wire                                csr_we,
   input  wire [spfc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [spfc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                 mismatch_count,
   output int                                 pending_count,
   output int                                 result_count,
   output int                                 good_polls,
   output int                                 bad_polls,
   output logic [spfc_pkg::BODY_AW-1:0]       rx_slot
);
   timeunit 1ns;
   timeprecision 1ps;

   import spfc_pkg::*;

   // register copies
   logic [7:0]          reload_cfg;
   logic [63:0]         msg_cfg;
   logic [3:0]          len_cfg;
   logic [5:0]          offset_cfg;

   // poller state
   logic [7:0]          body_mem [BODY_BYTES];
   logic [BODY_AW-1:0]  rx_slot_q;
   logic                body_full;
   logic                rx_on;
   logic                tx_busy;
   logic [3:0]          tx_slot;
   logic [7:0]          wait_left;

   rsp_type             batch[$];
   rsp_type             owed_results[$];

   function automatic rsp_type make_rsp(logic [1:0] k, logic [7:0] d, logic [5:0] p);
      rsp_type r;
      r.kind     = k;
      r.data     = d;
      r.position = p;
      r.last     = 1'b0;
      return r;
   endfunction

   function automatic logic frame_sum_ok();
      logic [7:0] total;
      total = 8'd0;
      for (int i = 0; i < BODY_BYTES - 1; i++)
         total = total + body_mem[i];
      return (8'd0 - total) == body_mem[BODY_BYTES-1];
   endfunction

   // emit the next request byte, or close the send once the message is out
   task automatic advance_send();
      logic [3:0] len;
      len = (len_cfg > 4'(REQ_MAX_BYTES)) ? 4'(REQ_MAX_BYTES) : len_cfg;
      if (tx_slot < len) begin
         batch.push_back(make_rsp(KIND_TX, msg_cfg[8*tx_slot +: 8], 6'(tx_slot)));
         tx_busy = 1'b1;
         tx_slot = tx_slot + 4'd1;
      end else begin
         rx_on   = 1'b1;
         tx_slot = 4'd0;
         tx_busy = 1'b0;
      end
   endtask

   task automatic absorb_event(req_type r);
      int      slot;
      rsp_type tail;
      batch.delete();
      case (r.func)
         FUNC_RX: begin
            if (rx_on) begin
               body_mem[rx_slot_q] = r.rx_data;
               if (rx_slot_q == BODY_AW'(BODY_BYTES - 1))
                  body_full = 1'b1;
               rx_slot_q = rx_slot_q + 1'b1;
            end
         end
         FUNC_TICK: begin
            if (wait_left != 8'd0)
               wait_left = wait_left - 8'd1;
         end
         FUNC_TX_DONE: advance_send();
         default: ;
      endcase

      if (body_full || wait_left == 8'd0) begin
         if (!tx_busy) begin
            rx_on = 1'b0;
            advance_send();
         end
         body_full = 1'b0;
         wait_left = reload_cfg;
         if (frame_sum_ok()) begin
            good_polls++;
            for (int i = 0; i < PAYLOAD_BYTES; i++) begin
               slot = i + offset_cfg;
               if (slot > BODY_BYTES - 1)
                  slot = BODY_BYTES - 1;
               batch.push_back(make_rsp(KIND_PAYLOAD, body_mem[slot], 6'(i)));
            end
         end else begin
            bad_polls++;
            batch.push_back(make_rsp(KIND_FAIL, 8'd0, 6'd0));
         end
      end

      if (batch.size() > 0) begin
         tail = batch[batch.size()-1];
         tail.last = 1'b1;
         batch[batch.size()-1] = tail;
      end
      foreach (batch[i])
         owed_results.push_back(batch[i]);
   endtask

   task automatic flag_field(string name, int unsigned want, int unsigned got);
      mismatch_count++;
      $error("%s: expected %0h, got %0h", name, want, got);
   endtask

   task automatic check_result(rsp_type got);
      rsp_type want;
      result_count++;
      if (owed_results.size() == 0) begin
         mismatch_count++;
         $error("result with nothing pending: kind %0d data %02h position %0d last %0b",
                got.kind, got.data, got.position, got.last);
      end else begin
         want = owed_results.pop_front();
         if (got.kind !== want.kind)         flag_field("kind", want.kind, got.kind);
         if (got.data !== want.data)         flag_field("data", want.data, got.data);
         if (got.position !== want.position) flag_field("position", want.position, got.position);
         if (got.last !== want.last)         flag_field("last", want.last, got.last);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (body_mem[i])
            body_mem[i] = 8'd0;
         rx_slot_q  = '0;
         body_full  = 1'b1;
         rx_on      = 1'b1;
         tx_busy    = 1'b0;
         tx_slot    = 4'd0;
         wait_left  = 8'd0;
         reload_cfg = 8'd0;
         msg_cfg    = 64'd0;
         len_cfg    = 4'd1;
         offset_cfg = 6'd0;
         owed_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TIMEOUT_RELOAD: reload_cfg = csr_wdata[7:0];
               CSR_REQUEST_BYTES:  msg_cfg    = csr_wdata;
               CSR_REQUEST_LENGTH: len_cfg    = csr_wdata[3:0];
               CSR_PAYLOAD_OFFSET: offset_cfg = csr_wdata[5:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            absorb_event(req_data);
         if (rsp_valid && rsp_ready)
            check_result(rsp_data);
      end
      pending_count = owed_results.size();
      rx_slot       = rx_slot_q;
   end

endmodule

>>> tb/serial_poll_frame_checksum_unit_test.sv
module serial_poll_frame_checksum_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import spfc_pkg::*;

   // func 3 carries no event, but the poll check still runs on it
   localparam logic [1:0] FUNC_NONE = 2'd3;

   localparam int TOTAL_REQUESTS = 410;
   // stop opening phases this far short of the total; a phase runs on past it
   localparam int PHASE_MARGIN   = 100;
   // a polling request sweeps the body and emits up to 60 bytes
   localparam int SETTLE_CYCLES  = 250;
   localparam int HOLD_CYCLES    = 400;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int                    mismatch_count;
   int                    pending_count;
   int                    result_count;
   int                    good_polls;
   int                    bad_polls;
   logic [BODY_AW-1:0]    rx_slot;

   int                    request_total = 0;
   int                    phase_no      = 0;
   int                    fill_slot;
   bit                    no_idle       = 1'b0;
   bit                    stall_request = 1'b0;
   bit                    stall_done    = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   serial_poll_frame_checksum_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   serial_poll_frame_checker frame_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .result_count   (result_count),
      .good_polls     (good_polls),
      .bad_polls      (bad_polls),
      .rx_slot        (rx_slot)
   );

   // Offer one request. Draw an idle gap first; with no gap, valid stays high
   // straight into the next request. Hold the payload until it is taken.
   task automatic offer(input logic [1:0] ev, input logic [7:0] rx_byte);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{func: ev, rx_data: rx_byte};
      do @(posedge clock); while (!req_ready);
      request_total++;
   endtask

   // Drop valid, wait until every predicted result is back, then give a
   // request that produced nothing time to finish inside the block.
   task automatic settle();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all four registers back to back; only call while the block is idle.
   task automatic write_settings(input logic [7:0] reload, input logic [63:0] msg,
                                 input logic [3:0] len, input logic [5:0] offset);
      csr_we    <= 1'b1;
      csr_index <= CSR_TIMEOUT_RELOAD;
      csr_wdata <= 64'(reload);
      @(posedge clock);
      csr_index <= CSR_REQUEST_BYTES;
      csr_wdata <= msg;
      @(posedge clock);
      csr_index <= CSR_REQUEST_LENGTH;
      csr_wdata <= 64'(len);
      @(posedge clock);
      csr_index <= CSR_PAYLOAD_OFFSET;
      csr_wdata <= 64'(offset);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Mostly legal lengths, sometimes zero or past the saturation point.
   function automatic logic [3:0] pick_length();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 8)
         return 4'(r + 1);
      else if (r == 8)
         return 4'd0;
      else
         return 4'($urandom_range(9, 15));
   endfunction

   // Favor the edges: start of body and the clamped end.
   function automatic logic [5:0] pick_offset();
      case ($urandom_range(0, 3))
         0:       return 6'd0;
         1:       return 6'd63;
         default: return 6'($urandom_range(0, 63));
      endcase
   endfunction

   // Clock out enough transmit-complete events to finish the longest request
   // and reopen the receiver, even if the first one triggers a fresh poll.
   task automatic finish_send();
      repeat (10) offer(FUNC_TX_DONE, 8'($urandom));
   endtask

   // One body: 63 random bytes plus the two's complement of their sum.
   // Corrupt one byte when asked so the checksum check fails.
   task automatic send_frame(input bit corrupt);
      logic [7:0] frame [BODY_BYTES];
      logic [7:0] total;
      int         hit;
      total = 8'd0;
      for (int i = 0; i < BODY_BYTES - 1; i++) begin
         frame[i] = 8'($urandom);
         total    = total + frame[i];
      end
      frame[BODY_BYTES-1] = 8'd0 - total;
      if (corrupt) begin
         hit        = $urandom_range(0, BODY_BYTES - 1);
         frame[hit] = frame[hit] ^ 8'($urandom_range(1, 255));
      end
      foreach (frame[i])
         offer(FUNC_RX, frame[i]);
   endtask

   // Result side: random backpressure per result, with one long hold-off
   // when the stimulus asks for it, so the block fills up and stops taking
   // requests.
   initial begin
      int unsigned gap;
      @(posedge clock);
      forever begin
         if (stall_request) begin
            stall_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = no_idle ? 0 : $urandom_range(0, 6);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      int unsigned r;
      logic [1:0]  ev;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Defaults: the body starts complete and the timeout at zero, so every
      // request polls. Hit both byte extremes, a tick at zero, every event
      // kind and the unused one.
      offer(FUNC_RX, 8'h00);
      offer(FUNC_RX, 8'hFF);
      offer(FUNC_TICK, 8'h00);
      offer(FUNC_TX_DONE, 8'hFF);
      offer(FUNC_NONE, 8'h5A);
      offer(FUNC_TX_DONE, 8'hA5);
      settle();

      // Zero request length: sends close at once, so the receiver stays open.
      // Offset 63 clamps every payload read to the last body byte.
      write_settings(8'd0, '1, 4'd0, 6'd63);
      offer(FUNC_RX, 8'hFF);
      offer(FUNC_RX, 8'h00);
      offer(FUNC_RX, 8'h80);
      offer(FUNC_RX, 8'h01);
      offer(FUNC_TICK, 8'hFF);
      offer(FUNC_NONE, 8'h00);
      offer(FUNC_TX_DONE, 8'h00);
      settle();

      // Longest timeout and a length past eight that must saturate.
      write_settings(8'd255, 64'h0123_4567_89AB_CDEF, 4'd15, 6'd62);
      offer(FUNC_TICK, 8'h00);
      repeat (8) offer(FUNC_TX_DONE, 8'h00);
      offer(FUNC_RX, 8'hFF);
      offer(FUNC_RX, 8'h00);
      offer(FUNC_TICK, 8'h00);

      // Alternate noisy phases with phases of well-formed bodies.
      while (request_total + PHASE_MARGIN < TOTAL_REQUESTS) begin
         settle();
         no_idle = ($urandom_range(0, 3) == 0);
         if (phase_no % 2 == 0) begin
            case ($urandom_range(0, 3))
               0:       r = 0;
               1:       r = 1;
               2:       r = 255;
               default: r = $urandom_range(2, 12);
            endcase
            write_settings(8'(r), {$urandom, $urandom}, pick_length(), pick_offset());
            // hold off the result side once while requests keep coming
            if (!stall_done) begin
               stall_request = 1'b1;
               stall_done    = 1'b1;
            end
            repeat ($urandom_range(30, 60)) begin
               r  = $urandom_range(0, 19);
               ev = (r < 10) ? FUNC_RX : (r < 15) ? FUNC_TICK :
                    (r < 19) ? FUNC_TX_DONE : FUNC_NONE;
               offer(ev, 8'($urandom));
            end
         end else begin
            // nonzero reload and no ticks: after the first poll, only full bodies trigger polls
            write_settings(8'($urandom_range(1, 255)), {$urandom, $urandom},
                           pick_length(), pick_offset());
            fill_slot = rx_slot;
            finish_send();
            // pad out a partial body so the next frame lands at slot zero
            if (fill_slot != 0) begin
               repeat (BODY_BYTES - fill_slot) offer(FUNC_RX, 8'($urandom));
               finish_send();
            end
            repeat ($urandom_range(1, 2)) begin
               send_frame($urandom_range(0, 3) == 0);
               finish_send();
            end
         end
         phase_no++;
      end

      settle();
      $display("summary: %0d requests over %0d random phases, %0d results checked",
               request_total, phase_no, result_count);
      $display("summary: %0d polls with a good checksum, %0d with a checksum error",
               good_polls, bad_polls);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog: worst case is far below this, even with every result stalled.
   initial begin
      #30ms;
      $display("tb: failure");
      $finish;
   end

endmodule

>>> serial_poll_frame_checksum_unit.f
src/spfc_pkg.sv
src/serial_poll_frame_checksum_unit.sv
tb/serial_poll_frame_checker.sv
tb/serial_poll_frame_checksum_unit_test.sv
